// File: design/assert_macros.svh
// Assertion helpers used by the checker file vlq_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/vlq_pkg.sv
package vlq_pkg;

  localparam int unsigned MAX_GROUPS  = 5;
  localparam int unsigned GROUP_BITS  = 7;
  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned VALUE_IN_W  = 31;
  localparam int unsigned VALUE_OUT_W = 32;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned MORE_IDX    = BYTE_W - 1;
  localparam int unsigned CNT_W       = $clog2(MAX_GROUPS + 1);
  localparam int unsigned PAD_W       = (MAX_GROUPS * GROUP_BITS > VALUE_IN_W) ?
                                        MAX_GROUPS * GROUP_BITS : VALUE_IN_W;

  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;
  localparam logic KIND_BYTE   = 1'b0;
  localparam logic KIND_VALUE  = 1'b1;

  typedef struct packed {
    logic                  mode;
    logic [VALUE_IN_W-1:0] value_in;
    logic [BYTE_W-1:0]     byte_in;
  } in_word_t;

  typedef struct packed {
    logic                   kind;
    logic [BYTE_W-1:0]      byte_out;
    logic [VALUE_OUT_W-1:0] value_out;
    logic                   last;
  } out_word_t;

  typedef enum logic {
    ST_IDLE,
    ST_ENC
  } ctrl_state_e;

  typedef struct packed {
    logic accept_enc;
    logic accept_dec;
    logic enc_step;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic is_decode;
    logic first_last;
    logic rem_last;
  } stat_t;

  // Number of 7-bit groups needed, at least one, saturating at MAX_GROUPS.
  function automatic logic [CNT_W-1:0] group_count(input logic [VALUE_IN_W-1:0] v);
    logic [PAD_W-1:0] p;
    logic [CNT_W-1:0] n;
    p = PAD_W'(v);
    n = CNT_W'(1);
    for (int k = 1; k < MAX_GROUPS; k++) begin
      if ((p >> (GROUP_BITS * k)) != '0) n = CNT_W'(k + 1);
    end
    return n;
  endfunction

  function automatic logic [GROUP_BITS-1:0] group_at(input logic [VALUE_IN_W-1:0] v,
                                                     input logic [CNT_W-1:0] idx);
    logic [PAD_W-1:0]      p;
    logic [GROUP_BITS-1:0] g;
    p = PAD_W'(v);
    g = '0;
    for (int k = 0; k < MAX_GROUPS; k++) begin
      if (idx == CNT_W'(k)) g = p[k*GROUP_BITS +: GROUP_BITS];
    end
    return g;
  endfunction

endpackage

// File: design/vlq_in_if.sv
interface vlq_in_if;
  logic               valid;
  logic               ready;
  vlq_pkg::in_word_t  data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
  modport monitor (input valid, input data, input ready);
endinterface

// File: design/vlq_out_if.sv
interface vlq_out_if;
  logic               valid;
  logic               ready;
  vlq_pkg::out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
  modport monitor (input valid, input data, input ready);
endinterface

// File: design/vlq_msb_first_codec.sv
// Channel  Dir  Payload                                   Handshake
// in_ch    in   mode, value_in[30:0], byte_in[7:0]         valid/ready
// out_ch   out  kind, byte_out[7:0], value_out[31:0], last valid/ready
//
// Decode: each byte is taken when the output is free; a byte with bit 7 clear yields one value word.
// Encode: one to MAX_GROUPS bytes per value, one byte per cycle from the output register
// while the output is free; the byte counter in the datapath counts the bytes left.
// Reset clears the decode accumulator, the sequencer and the output valid.
// A stalled output word holds and blocks the sequencer until taken.
module vlq_msb_first_codec (
  input  logic      clk_i,
  input  logic      rst_ni,
  vlq_in_if.sink    in_ch,
  vlq_out_if.source out_ch
);

  vlq_pkg::cmd_t  cmd;
  vlq_pkg::stat_t stat;

  vlq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch.valid),
    .stat_i     (stat),
    .in_ready_o (in_ch.ready),
    .cmd_o      (cmd)
  );

  vlq_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_ch.data),
    .out_ready_i (out_ch.ready),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_ch.valid),
    .out_data_o  (out_ch.data)
  );

endmodule

// File: design/vlq_ctrl.sv
module vlq_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  vlq_pkg::stat_t  stat_i,
  output logic            in_ready_o,
  output vlq_pkg::cmd_t   cmd_o
);

  vlq_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= vlq_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      vlq_pkg::ST_IDLE: begin
        in_ready_o = stat_i.out_free;
        if (in_valid_i && stat_i.out_free) begin
          if (stat_i.is_decode) begin
            cmd_o.accept_dec = 1'b1;
          end else begin
            // first byte goes out on accept, the rest one per cycle while the output is free
            cmd_o.accept_enc = 1'b1;
            if (!stat_i.first_last) state_d = vlq_pkg::ST_ENC;
          end
        end
      end
      vlq_pkg::ST_ENC: begin
        if (stat_i.out_free) begin
          cmd_o.enc_step = 1'b1;
          if (stat_i.rem_last) state_d = vlq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = vlq_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// File: design/vlq_dp.sv
module vlq_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  vlq_pkg::in_word_t  in_data_i,
  input  logic               out_ready_i,
  input  vlq_pkg::cmd_t      cmd_i,
  output vlq_pkg::stat_t     stat_o,
  output logic               out_valid_o,
  output vlq_pkg::out_word_t out_data_o
);

  logic [vlq_pkg::VALUE_IN_W-1:0]  val_q;
  logic [vlq_pkg::CNT_W-1:0]       rem_q;
  logic [vlq_pkg::VALUE_WIDTH-1:0] acc_q, acc_d;
  logic [vlq_pkg::VALUE_WIDTH-1:0] acc_nxt;
  logic                            out_valid_q, out_valid_d;
  vlq_pkg::out_word_t              out_q, out_d;

  logic [vlq_pkg::CNT_W-1:0]       n_groups;
  logic [vlq_pkg::CNT_W-1:0]       step_idx;
  logic [vlq_pkg::GROUP_BITS-1:0]  first_grp, step_grp;
  logic                            dec_final;

  assign n_groups  = vlq_pkg::group_count(in_data_i.value_in);
  assign first_grp = vlq_pkg::group_at(in_data_i.value_in, n_groups - vlq_pkg::CNT_W'(1));
  assign step_idx  = rem_q - vlq_pkg::CNT_W'(1);
  assign step_grp  = vlq_pkg::group_at(val_q, step_idx);
  assign acc_nxt   = vlq_pkg::VALUE_WIDTH'({acc_q, in_data_i.byte_in[vlq_pkg::GROUP_BITS-1:0]});
  assign dec_final = !in_data_i.byte_in[vlq_pkg::MORE_IDX];

  assign stat_o.out_free   = !out_valid_q || out_ready_i;
  assign stat_o.is_decode  = (in_data_i.mode == vlq_pkg::MODE_DECODE);
  assign stat_o.first_last = (n_groups == vlq_pkg::CNT_W'(1));
  assign stat_o.rem_last   = (rem_q == vlq_pkg::CNT_W'(1));

  always_comb begin
    acc_d       = acc_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (cmd_i.accept_enc) begin
      out_valid_d     = 1'b1;
      out_d.kind      = vlq_pkg::KIND_BYTE;
      out_d.byte_out  = {!stat_o.first_last, first_grp};
      out_d.value_out = '0;
      out_d.last      = stat_o.first_last;
    end else if (cmd_i.enc_step) begin
      out_valid_d     = 1'b1;
      out_d.kind      = vlq_pkg::KIND_BYTE;
      out_d.byte_out  = {!stat_o.rem_last, step_grp};
      out_d.value_out = '0;
      out_d.last      = stat_o.rem_last;
    end else if (cmd_i.accept_dec) begin
      if (dec_final) begin
        acc_d           = '0;
        out_valid_d     = 1'b1;
        out_d.kind      = vlq_pkg::KIND_VALUE;
        out_d.byte_out  = '0;
        out_d.value_out = vlq_pkg::VALUE_OUT_W'(acc_nxt);
        out_d.last      = 1'b1;
      end else begin
        acc_d = acc_nxt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      out_valid_q <= 1'b0;
      rem_q       <= '0;
    end else begin
      acc_q       <= acc_d;
      out_valid_q <= out_valid_d;
      if (cmd_i.accept_enc) begin
        rem_q <= n_groups - vlq_pkg::CNT_W'(1);
      end else if (cmd_i.enc_step) begin
        rem_q <= step_idx;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (cmd_i.accept_enc) val_q <= in_data_i.value_in;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: design/vlq_checker.sv
`include "assert_macros.svh"

module vlq_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input vlq_pkg::out_word_t out_data_i
);

  logic value_word;
  logic byte_word;
  logic mid_burst;
  logic value_ok;
  logic byte_ok;

  assign value_word = out_valid_i && (out_data_i.kind == vlq_pkg::KIND_VALUE);
  assign byte_word  = out_valid_i && (out_data_i.kind == vlq_pkg::KIND_BYTE);
  assign mid_burst  = byte_word && !out_data_i.last;
  assign value_ok   = out_data_i.last && (out_data_i.byte_out == '0);
  assign byte_ok    = (out_data_i.byte_out[vlq_pkg::MORE_IDX] == !out_data_i.last) &&
                      (out_data_i.value_out == '0);

  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_data_i), "stalled output word changed")
  `ASSERT_ALWAYS(a_value_last, clk_i, rst_ni, !value_word || value_ok, "decoded value word malformed")
  `ASSERT_ALWAYS(a_more_bit, clk_i, rst_ni, !byte_word || byte_ok, "continuation bit disagrees with last")
  `ASSERT_ALWAYS(a_no_accept_mid_enc, clk_i, rst_ni, !mid_burst || !in_ready_i, "input taken during an encode burst")

endmodule

bind vlq_msb_first_codec vlq_checker u_vlq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_ch.ready),
  .out_valid_i (out_ch.valid),
  .out_ready_i (out_ch.ready),
  .out_data_i  (out_ch.data)
);
